>>> rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// TSC package
// Types and constants shared by the TCP segment header checksum block.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_PORT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_TO_LIVE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE   = 3'd6;

    localparam logic [7:0]       TTL_RESET      = 8'd123;
    localparam logic [15:0]      WINDOW_RESET   = 16'd400;
    localparam logic [LEN_W-1:0] SEGMENT_RESET  = 11'd512;

    localparam logic [15:0]      IP_VER_WORD    = 16'h4500;
    localparam logic [7:0]       PROTO_TCP      = 8'h06;
    localparam logic [15:0]      TCP_FLAGS_WORD = 16'h5018;
    localparam logic [LEN_W-1:0] IP_HDR_BYTES   = 11'd40;
    localparam logic [LEN_W-1:0] TCP_HDR_BYTES  = 11'd20;

    localparam int CFG_SUM_W = 20;
    localparam int RAW_SUM_W = 21;

    typedef struct packed {
        logic [31:0]      seq;
        logic [31:0]      ack;
        logic [15:0]      ident;
        logic [LEN_W-1:0] len;
        logic             last;
        logic [15:0]      data_sum;
        logic [15:0]      pad_word;
    } tsc_seg_t;

    typedef struct packed {
        logic [31:0]      seq_number;
        logic [31:0]      ack_number;
        logic [15:0]      ident_out;
        logic [LEN_W-1:0] payload_length;
        logic [LEN_W-1:0] ip_total_length;
        logic [15:0]      ip_checksum;
        logic [15:0]      tcp_checksum;
        logic             last_segment;
    } tsc_desc_t;

endpackage

>>> rtl/core/tsc_ifs.sv
// ----------------------------------------------------------------------------
// TSC channel interfaces
// Byte input, descriptor output and configuration write channels.
// ----------------------------------------------------------------------------
interface tsc_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] seq_start;
    logic [31:0] ack_value;
    logic [15:0] packet_ident;

    modport source (output valid, payload_byte, last_byte, seq_start, ack_value,
                    packet_ident, input ready);
    modport sink (input valid, payload_byte, last_byte, seq_start, ack_value,
                  packet_ident, output ready);
endinterface

interface tsc_desc_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] ident_out;
    logic [10:0] payload_length;
    logic [10:0] ip_total_length;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic        last_segment;

    modport source (output valid, seq_number, ack_number, ident_out, payload_length,
                    ip_total_length, ip_checksum, tcp_checksum, last_segment,
                    input ready);
    modport sink (input valid, seq_number, ack_number, ident_out, payload_length,
                  ip_total_length, ip_checksum, tcp_checksum, last_segment,
                  output ready);
endinterface

interface tsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tsc_csum.sv
// ----------------------------------------------------------------------------
// TSC checksum pipeline
// Adds segment terms to the configured header sums, folds and complements.
// ----------------------------------------------------------------------------
module tsc_csum
    import tsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seg_valid,
    output logic                 seg_ready,
    input  tsc_seg_t             seg,
    input  logic [CFG_SUM_W-1:0] tcp_cfg_sum,
    input  logic [CFG_SUM_W-1:0] ip_cfg_sum,
    output logic                 desc_valid,
    input  logic                 desc_ready,
    output tsc_desc_t            desc
);

    logic                 sum_valid_reg;
    tsc_seg_t             sum_seg_reg;
    logic [RAW_SUM_W-1:0] tcp_raw_reg;
    logic [RAW_SUM_W-1:0] ip_raw_reg;
    logic [RAW_SUM_W-1:0] tcp_raw_next;
    logic [RAW_SUM_W-1:0] ip_raw_next;
    logic                 desc_valid_reg;
    tsc_desc_t            desc_reg;
    tsc_desc_t            desc_next;
    logic                 out_free;
    logic                 sum_free;
    logic [16:0]          tcp_fold1;
    logic [16:0]          ip_fold1;
    logic [15:0]          tcp_fold2;
    logic [15:0]          ip_fold2;

    assign out_free  = !desc_valid_reg || desc_ready;
    assign sum_free  = !sum_valid_reg || out_free;
    assign seg_ready = sum_free;

    assign tcp_raw_next = RAW_SUM_W'(tcp_cfg_sum)
                        + RAW_SUM_W'(seg.data_sum) + RAW_SUM_W'(seg.pad_word)
                        + RAW_SUM_W'(seg.len)
                        + RAW_SUM_W'(seg.seq[31:16]) + RAW_SUM_W'(seg.seq[15:0])
                        + RAW_SUM_W'(seg.ack[31:16]) + RAW_SUM_W'(seg.ack[15:0]);
    assign ip_raw_next  = RAW_SUM_W'(ip_cfg_sum) + RAW_SUM_W'(seg.len)
                        + RAW_SUM_W'(seg.ident);

    assign tcp_fold1 = {1'b0, tcp_raw_reg[15:0]} + 17'(tcp_raw_reg[RAW_SUM_W-1:16]);
    assign tcp_fold2 = tcp_fold1[15:0] + 16'(tcp_fold1[16]);
    assign ip_fold1  = {1'b0, ip_raw_reg[15:0]} + 17'(ip_raw_reg[RAW_SUM_W-1:16]);
    assign ip_fold2  = ip_fold1[15:0] + 16'(ip_fold1[16]);

    always_comb
    begin
        desc_next.seq_number      = sum_seg_reg.seq;
        desc_next.ack_number      = sum_seg_reg.ack;
        desc_next.ident_out       = sum_seg_reg.ident;
        desc_next.payload_length  = sum_seg_reg.len;
        desc_next.ip_total_length = sum_seg_reg.len + IP_HDR_BYTES;
        desc_next.ip_checksum     = ~ip_fold2;
        desc_next.tcp_checksum    = ~tcp_fold2;
        desc_next.last_segment    = sum_seg_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_free)
            begin
                sum_valid_reg <= seg_valid;
            end
            if (out_free)
            begin
                desc_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_free && seg_valid)
        begin
            sum_seg_reg <= seg;
            tcp_raw_reg <= tcp_raw_next;
            ip_raw_reg  <= ip_raw_next;
        end
        if (out_free && sum_valid_reg)
        begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

>>> rtl/core/tcp_segment_header_checksum.sv
// ----------------------------------------------------------------------------
// TCP segment header checksum
// Cuts a byte stream into segments and builds one descriptor per segment,
// with IPv4 header and TCP checksums.
//
//   channel   dir   handshake      word
//   byte_ch   in    valid/ready    payload_byte, last_byte, seq_start, ...
//   desc_ch   out   valid/ready    seq_number ... last_segment
//   cfg_ch    in    valid/ready    index (3), data (32); ready always high
//
// One byte per cycle is accepted while the segment register can take it. A descriptor
// is built from the byte closing its segment through the segment register, the
// sum stage and the fold stage.
// Reset clears the message state and loads the register reset values.
// A stalled output holds its word; bytes keep flowing until all three
// stages are full.
// ----------------------------------------------------------------------------
module tcp_segment_header_checksum
    import tsc_pkg::*;
#(
    parameter int MAX_SEGMENT_BYTES = 1460,
    parameter int MAX_MESSAGE_BYTES = 65535
)
(
    input  logic     clk,
    input  logic     rst_n,
    tsc_byte_if.sink byte_ch,
    tsc_desc_if.source desc_ch,
    tsc_cfg_if.sink  cfg_ch
);

    localparam int SEG_W = $clog2(MAX_SEGMENT_BYTES + 1);
    localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [31:0]          src_addr_reg;
    logic [31:0]          dst_addr_reg;
    logic [15:0]          src_port_reg;
    logic [15:0]          dst_port_reg;
    logic [7:0]           ttl_reg;
    logic [15:0]          window_reg;
    logic [LEN_W-1:0]     seg_size_reg;
    logic [CFG_SUM_W-1:0] tcp_cfg_sum_reg;
    logic [CFG_SUM_W-1:0] ip_cfg_sum_reg;

    logic [15:0]          sum_reg;
    logic [SEG_W-1:0]     count_reg;
    logic [OFF_W-1:0]     offset_reg;
    logic [7:0]           held_reg;
    logic                 pending_reg;
    logic [31:0]          lseq_reg;
    logic [31:0]          lack_reg;
    logic [15:0]          lident_reg;
    logic                 in_msg_reg;

    logic                 seg_valid_reg;
    tsc_seg_t             seg_reg;
    tsc_seg_t             seg_next;

    logic                 seg_ready;
    logic                 csum_ready;
    logic                 accept;
    logic                 first;
    logic [31:0]          cur_seq;
    logic [31:0]          cur_ack;
    logic [15:0]          cur_ident;
    logic [15:0]          cur_sum;
    logic                 cur_pending;
    logic [SEG_W-1:0]     cur_count;
    logic [OFF_W-1:0]     cur_offset;
    logic [16:0]          pair_sum;
    logic [15:0]          sum_next;
    logic [7:0]           held_next;
    logic                 pending_next;
    logic [SEG_W-1:0]     count_next;
    logic [SEG_W-1:0]     limit;
    logic [OFF_W:0]       total;
    logic                 last;
    logic                 emit;
    tsc_desc_t            desc;

    assign seg_ready    = 1'b1 & 1'b1;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            src_port_reg <= '0;
            dst_port_reg <= '0;
            ttl_reg      <= TTL_RESET;
            window_reg   <= WINDOW_RESET;
            seg_size_reg <= SEGMENT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_SOURCE_ADDRESS: src_addr_reg <= cfg_ch.data;
                REG_DEST_ADDRESS:   dst_addr_reg <= cfg_ch.data;
                REG_SOURCE_PORT:    src_port_reg <= cfg_ch.data[15:0];
                REG_DEST_PORT:      dst_port_reg <= cfg_ch.data[15:0];
                REG_TIME_TO_LIVE:   ttl_reg      <= cfg_ch.data[7:0];
                REG_WINDOW_SIZE:    window_reg   <= cfg_ch.data[15:0];
                REG_SEGMENT_SIZE:   seg_size_reg <= cfg_ch.data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // precompute header terms that depend on registers only
    always_ff @(posedge clk)
    begin
        tcp_cfg_sum_reg <= CFG_SUM_W'(src_addr_reg[31:16]) + CFG_SUM_W'(src_addr_reg[15:0])
                         + CFG_SUM_W'(dst_addr_reg[31:16]) + CFG_SUM_W'(dst_addr_reg[15:0])
                         + CFG_SUM_W'(src_port_reg) + CFG_SUM_W'(dst_port_reg)
                         + CFG_SUM_W'(PROTO_TCP) + CFG_SUM_W'(TCP_HDR_BYTES)
                         + CFG_SUM_W'(TCP_FLAGS_WORD) + CFG_SUM_W'(window_reg);
        ip_cfg_sum_reg  <= CFG_SUM_W'(IP_VER_WORD) + CFG_SUM_W'(IP_HDR_BYTES)
                         + CFG_SUM_W'({ttl_reg, PROTO_TCP})
                         + CFG_SUM_W'(src_addr_reg[31:16]) + CFG_SUM_W'(src_addr_reg[15:0])
                         + CFG_SUM_W'(dst_addr_reg[31:16]) + CFG_SUM_W'(dst_addr_reg[15:0]);
    end

    logic snap_free;

    assign snap_free    = !seg_valid_reg || (seg_ready && csum_ready);
    assign byte_ch.ready = snap_free;
    assign accept       = byte_ch.valid && snap_free;
    assign first        = !in_msg_reg;

    assign cur_seq     = first ? byte_ch.seq_start    : lseq_reg;
    assign cur_ack     = first ? byte_ch.ack_value    : lack_reg;
    assign cur_ident   = first ? byte_ch.packet_ident : lident_reg;
    assign cur_sum     = first ? '0 : sum_reg;
    assign cur_pending = first ? 1'b0 : pending_reg;
    assign cur_count   = first ? '0 : count_reg;
    assign cur_offset  = first ? '0 : offset_reg;

    assign pair_sum = {1'b0, cur_sum} + {1'b0, held_reg, byte_ch.payload_byte};

    always_comb
    begin
        if (cur_pending)
        begin
            sum_next     = pair_sum[15:0] + 16'(pair_sum[16]);
            held_next    = held_reg;
            pending_next = 1'b0;
        end
        else
        begin
            sum_next     = cur_sum;
            held_next    = byte_ch.payload_byte;
            pending_next = 1'b1;
        end
    end

    assign count_next = cur_count + SEG_W'(1);

    always_comb
    begin
        if (seg_size_reg == '0)
        begin
            limit = SEG_W'(1);
        end
        else if (seg_size_reg > LEN_W'(MAX_SEGMENT_BYTES))
        begin
            limit = SEG_W'(MAX_SEGMENT_BYTES);
        end
        else
        begin
            limit = seg_size_reg[SEG_W-1:0];
        end
    end

    assign total = (OFF_W+1)'(cur_offset) + (OFF_W+1)'(count_next);
    assign last  = byte_ch.last_byte || (total >= (OFF_W+1)'(MAX_MESSAGE_BYTES));
    assign emit  = last || (count_next >= limit);

    always_comb
    begin
        seg_next.seq      = cur_seq + 32'(cur_offset);
        seg_next.ack      = cur_ack;
        seg_next.ident    = cur_ident;
        seg_next.len      = LEN_W'(count_next);
        seg_next.last     = last;
        seg_next.data_sum = sum_next;
        seg_next.pad_word = pending_next ? {held_next, 8'h00} : 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            held_reg      <= '0;
            pending_reg   <= 1'b0;
            lseq_reg      <= '0;
            lack_reg      <= '0;
            lident_reg    <= '0;
            in_msg_reg    <= 1'b0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_free)
            begin
                seg_valid_reg <= accept && emit;
            end
            if (accept)
            begin
                lseq_reg   <= cur_seq;
                lack_reg   <= cur_ack;
                lident_reg <= cur_ident;
                if (emit)
                begin
                    sum_reg     <= '0;
                    count_reg   <= '0;
                    held_reg    <= '0;
                    pending_reg <= 1'b0;
                    in_msg_reg  <= !last;
                    offset_reg  <= last ? '0 : total[OFF_W-1:0];
                end
                else
                begin
                    sum_reg     <= sum_next;
                    count_reg   <= count_next;
                    held_reg    <= held_next;
                    pending_reg <= pending_next;
                    in_msg_reg  <= 1'b1;
                    offset_reg  <= cur_offset;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            seg_reg <= seg_next;
        end
    end

    tsc_csum u_csum (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg_valid   (seg_valid_reg),
        .seg_ready   (csum_ready),
        .seg         (seg_reg),
        .tcp_cfg_sum (tcp_cfg_sum_reg),
        .ip_cfg_sum  (ip_cfg_sum_reg),
        .desc_valid  (desc_ch.valid),
        .desc_ready  (desc_ch.ready),
        .desc        (desc)
    );

    assign desc_ch.seq_number      = desc.seq_number;
    assign desc_ch.ack_number      = desc.ack_number;
    assign desc_ch.ident_out       = desc.ident_out;
    assign desc_ch.payload_length  = desc.payload_length;
    assign desc_ch.ip_total_length = desc.ip_total_length;
    assign desc_ch.ip_checksum     = desc.ip_checksum;
    assign desc_ch.tcp_checksum    = desc.tcp_checksum;
    assign desc_ch.last_segment    = desc.last_segment;

endmodule

>>> rtl/core/tsc_checker.sv
// ----------------------------------------------------------------------------
// TSC port checker
// Watches the descriptor channel of the top level over time.
// ----------------------------------------------------------------------------
module tsc_checker
    import tsc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             desc_valid,
    input logic             desc_ready,
    input logic [LEN_W-1:0] payload_length,
    input logic [LEN_W-1:0] ip_total_length,
    input logic [15:0]      ip_checksum,
    input logic [31:0]      seq_number
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && !desc_ready |=> desc_valid && $stable(seq_number)
                                      && $stable(ip_checksum))
        else $error("descriptor dropped or changed while stalled");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> ip_total_length == payload_length + IP_HDR_BYTES)
        else $error("ip total length does not match payload length");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> payload_length != '0)
        else $error("empty segment emitted");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !desc_valid)
        else $error("descriptor valid right after reset");

endmodule

bind tcp_segment_header_checksum tsc_checker u_tsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc_valid      (desc_ch.valid),
    .desc_ready      (desc_ch.ready),
    .payload_length  (desc_ch.payload_length),
    .ip_total_length (desc_ch.ip_total_length),
    .ip_checksum     (desc_ch.ip_checksum),
    .seq_number      (desc_ch.seq_number)
);
